@@ rtl/core/vector3_normalize_core_macros.svh @@
// Assertion macros for the vector normalize RTL.
`ifndef VECTOR3_NORMALIZE_CORE_MACROS_SVH
`define VECTOR3_NORMALIZE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define V3N_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define V3N_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/v3n_pkg.sv @@
// Types and constants of the 3D vector normalize core.
package v3n_pkg;

    localparam int COMPONENT_WIDTH    = 24;
    localparam int UNIT_FRACTION_BITS = 30;
    localparam int LENGTH_WIDTH       = 32;
    localparam int UNIT_WIDTH         = 32;

    // Sum of squares stays below 2^(2*COMPONENT_WIDTH); radicand carries 16 more bits
    localparam int SUM_WIDTH  = 2 * COMPONENT_WIDTH;
    localparam int RAD_WIDTH  = SUM_WIDTH + 16;
    localparam int ROOT_WIDTH = RAD_WIDTH / 2;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] comp_x;
        logic signed [COMPONENT_WIDTH-1:0] comp_y;
        logic signed [COMPONENT_WIDTH-1:0] comp_z;
    } vec_item_t;

    typedef struct packed {
        logic        [LENGTH_WIDTH-1:0] vector_length;
        logic signed [UNIT_WIDTH-1:0]   unit_x;
        logic signed [UNIT_WIDTH-1:0]   unit_y;
        logic signed [UNIT_WIDTH-1:0]   unit_z;
        logic                           zero_vector;
    } res_item_t;

endpackage

@@ rtl/core/v3n_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage.
module v3n_sqrt_pipe (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [v3n_pkg::RAD_WIDTH-1:0]        rad,
    output logic [v3n_pkg::ROOT_WIDTH-1:0]       root
);

    localparam int RAD_W  = v3n_pkg::RAD_WIDTH;
    localparam int ROOT_W = v3n_pkg::ROOT_WIDTH;
    localparam int REM_W  = ROOT_W + 2;

    // Stage registers; the last stage keeps only the root
    logic [RAD_W-1:0]  rad_reg  [1:ROOT_W-1];
    logic [ROOT_W-1:0] rem_reg  [1:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic [RAD_W-1:0]  rad_cur;
        logic [ROOT_W-1:0] rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (i == 0) begin : g_first
            assign rad_cur  = rad;
            assign rem_cur  = '0;
            assign root_cur = '0;
        end else begin : g_mid
            assign rad_cur  = rad_reg[i];
            assign rem_cur  = rem_reg[i];
            assign root_cur = root_reg[i];
        end

        // Bring down two radicand bits, try root*4+1
        always_comb
        begin
            rem_sh = {rem_cur, rad_cur[RAD_W-1 -: 2]};
            trial  = {root_cur, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_cur[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_cur[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i+1] <= root_next;
            end
        end

        if (i < ROOT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[i+1] <= rad_cur << 2;
                    rem_reg[i+1] <= rem_next[ROOT_W-1:0];
                end
            end
        end
    end

    assign root = root_reg[ROOT_W];

endmodule

@@ rtl/core/v3n_div_lane.sv @@
// One divider lane: quotient of magnitude * 2^(F+8) over the Q.8 length.
module v3n_div_lane #(
    parameter int UNIT_FRACTION_BITS = v3n_pkg::UNIT_FRACTION_BITS
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [v3n_pkg::COMPONENT_WIDTH-1:0]    mag,
    input  logic [v3n_pkg::ROOT_WIDTH-1:0]         len,
    output logic [UNIT_FRACTION_BITS:0]            quot
);

    localparam int ROOT_W = v3n_pkg::ROOT_WIDTH;
    localparam int QW     = UNIT_FRACTION_BITS + 1;

    logic [ROOT_W-1:0] rem_reg [1:QW-1];
    logic [ROOT_W-1:0] len_reg [1:QW-1];
    logic [QW-1:0]     q_reg   [1:QW];

    // mag*256 <= len, so mag*128 starts below the divisor
    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [ROOT_W-1:0] rem_cur;
        logic [ROOT_W-1:0] len_cur;
        logic [QW-1:0]     q_cur;
        logic [ROOT_W:0]   rem_sh;
        logic              ge;
        logic [ROOT_W:0]   rem_next;
        logic [QW-1:0]     q_next;

        if (j == 0) begin : g_first
            assign rem_cur = ROOT_W'({mag, 7'b0});
            assign len_cur = len;
            assign q_cur   = '0;
        end else begin : g_mid
            assign rem_cur = rem_reg[j];
            assign len_cur = len_reg[j];
            assign q_cur   = q_reg[j];
        end

        // Restoring step
        always_comb
        begin
            rem_sh   = {rem_cur, 1'b0};
            ge       = (rem_sh >= {1'b0, len_cur});
            rem_next = ge ? (rem_sh - {1'b0, len_cur}) : rem_sh;
            q_next   = {q_cur[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1] <= q_next;
            end
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= rem_next[ROOT_W-1:0];
                    len_reg[j+1] <= len_cur;
                end
            end
        end
    end

    assign quot = q_reg[QW];

endmodule

@@ rtl/core/vector3_normalize_core.sv @@
// Top level of the 3D vector normalize core: length and unit vector per transfer.
//
// Input channel vec (vec_valid, vec_stall) carries one signed 3D vector per
// transfer. Output channel res (res_valid, res_stall) returns one result per
// vector: the length floor(256*sqrt(x^2+y^2+z^2)), the three unit components
// in Q1.F truncated toward zero and clamped to +/-2^F, and a zero-vector flag.
// A transfer happens when valid is high and stall is low.
//
// A vector passes through the input stage, the squares, the sum, the square root
// stages, the divider stages and the merge register. Throughput is one vector per
// cycle while res is not stalled, set by the fully pipelined square root (one root
// bit per stage) and three divider lanes (one quotient bit per stage) that work side by side.
//
// The whole pipeline advances together. While res holds a result that the
// receiver stalls, the pipeline freezes and vec_stall is high; otherwise a new
// vector is taken every cycle. Reset clears all valid bits; no clearing pass.
module vector3_normalize_core #(
    parameter int UNIT_FRACTION_BITS = v3n_pkg::UNIT_FRACTION_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vec_valid,
    output logic               vec_stall,
    input  v3n_pkg::vec_item_t vec,
    output logic               res_valid,
    input  logic               res_stall,
    output v3n_pkg::res_item_t res
);

    `include "vector3_normalize_core_macros.svh"

    localparam int CW      = v3n_pkg::COMPONENT_WIDTH;
    localparam int SUM_W   = v3n_pkg::SUM_WIDTH;
    localparam int ROOT_W  = v3n_pkg::ROOT_WIDTH;
    localparam int LEN_W   = v3n_pkg::LENGTH_WIDTH;
    localparam int UNIT_W  = v3n_pkg::UNIT_WIDTH;
    localparam int QW      = UNIT_FRACTION_BITS + 1;
    localparam int DIV_IDX = 2 + ROOT_W;
    localparam int DEPTH   = DIV_IDX + QW;

    localparam logic [QW-1:0] Q_LIMIT = QW'(1) << UNIT_FRACTION_BITS;
    localparam logic signed [UNIT_W-1:0] UNIT_MAX = UNIT_W'(Q_LIMIT);
    localparam logic signed [UNIT_W-1:0] UNIT_MIN = -UNIT_MAX;

    typedef struct packed {
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
    } side_t;

    logic                adv;
    logic [DEPTH:0]      vld_reg;
    side_t               side_reg [0:DEPTH];
    side_t               side_next;
    logic [SUM_W-1:0]    sq_reg [3];
    logic [SUM_W-1:0]    sum_reg;
    logic [ROOT_W-1:0]   root;
    logic [QW-1:0]       quot [3];
    logic                res_vld_reg;
    v3n_pkg::res_item_t  res_reg;
    v3n_pkg::res_item_t  res_next;

    // Global advance: hold everything while the output is stalled
    assign adv       = !(res_vld_reg && res_stall);
    assign vec_stall = !adv;

    // Input stage: sign and magnitude per lane
    always_comb
    begin
        logic signed [CW-1:0] c [3];
        c[0] = vec.comp_x;
        c[1] = vec.comp_y;
        c[2] = vec.comp_z;
        for (int k = 0; k < 3; k++)
        begin
            side_next.neg[k] = c[k][CW-1];
            side_next.mag[k] = c[k][CW-1] ? CW'(-c[k]) : CW'(c[k]);
        end
        side_next.zero = (side_next.mag[0] == '0) && (side_next.mag[1] == '0)
                         && (side_next.mag[2] == '0);
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[DEPTH-1:0], vec_valid};
            res_vld_reg <= vld_reg[DEPTH];
        end
    end

    // Sideband line, squares and sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int j = 1; j <= DEPTH; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= SUM_W'(side_reg[0].mag[k]) * SUM_W'(side_reg[0].mag[k]);
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // Q.8 length: floor(sqrt(sum * 2^16))
    v3n_sqrt_pipe u_sqrt (
        .clk   (clk),
        .en    (adv),
        .rad   ({sum_reg, 16'b0}),
        .root  (root)
    );

    // Divider lanes, one per component
    for (genvar k = 0; k < 3; k++) begin : g_lane
        v3n_div_lane #(
            .UNIT_FRACTION_BITS (UNIT_FRACTION_BITS)
        ) u_div (
            .clk   (clk),
            .en    (adv),
            .mag   (side_reg[DIV_IDX].mag[k]),
            .len   (root),
            .quot  (quot[k])
        );
    end

    // Length travels beside the divider lanes for the merge stage
    logic [ROOT_W-1:0] len_reg [1:QW];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg[1] <= root;
            for (int j = 2; j <= QW; j++)
            begin
                len_reg[j] <= len_reg[j-1];
            end
        end
    end

    // Merge: clamp, apply signs, saturate length, zero vector
    always_comb
    begin
        logic [QW-1:0]            q_sat;
        logic signed [UNIT_W-1:0] u [3];
        for (int k = 0; k < 3; k++)
        begin
            q_sat = (quot[k] > Q_LIMIT) ? Q_LIMIT : quot[k];
            u[k]  = side_reg[DEPTH].neg[k] ? -UNIT_W'(q_sat) : UNIT_W'(q_sat);
        end
        if ((ROOT_W > LEN_W) && ((len_reg[QW] >> LEN_W) != '0))
        begin
            res_next.vector_length = '1;
        end
        else
        begin
            res_next.vector_length = LEN_W'(len_reg[QW]);
        end
        res_next.unit_x      = u[0];
        res_next.unit_y      = u[1];
        res_next.unit_z      = u[2];
        res_next.zero_vector = side_reg[DEPTH].zero;
        if (side_reg[DEPTH].zero)
        begin
            res_next = '0;
            res_next.zero_vector = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    `V3N_ASSERT_NOW(a_zero_clean, res_valid && res.zero_vector,
        (res.vector_length == '0) && (res.unit_x == '0) && (res.unit_y == '0)
        && (res.unit_z == '0), "zero vector result not cleared")
    `V3N_ASSERT_NOW(a_len_floor, res_valid && !res.zero_vector,
        res.vector_length >= LEN_W'(256), "nonzero vector shorter than one")
    `V3N_ASSERT_NOW(a_unit_range, res_valid && !res.zero_vector,
        (res.unit_x <= UNIT_MAX) && (res.unit_x >= UNIT_MIN) && (res.unit_y <= UNIT_MAX)
        && (res.unit_y >= UNIT_MIN) && (res.unit_z <= UNIT_MAX)
        && (res.unit_z >= UNIT_MIN), "unit component out of range")
    `V3N_ASSERT_NEXT(a_freeze, res_valid && res_stall,
        $stable(vld_reg), "pipeline moved under output stall")

endmodule
